// ===== rtl/core/rcoe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rcoe_pkg;

   localparam int CoreDepthDefault = 8192;

   localparam int WordW = 40;
   localparam int NumW  = 13;
   localparam int RegW  = 14;
   localparam int SumW  = RegW + 1;
   localparam int FuncW = 2;
   localparam int ModeW = 3;
   localparam int CsrIdxW = 2;

   // instruction word layout
   localparam int AnumLsb  = 0;
   localparam int BnumLsb  = 13;
   localparam int AmodeLsb = 26;
   localparam int BmodeLsb = 29;

   localparam logic [RegW-1:0] CoreSizeReset  = RegW'(8000);
   localparam logic [RegW-1:0] ReadLimitReset = RegW'(8000);
   localparam logic [RegW-1:0] WriteLimitReset = RegW'(8000);

   localparam logic [FuncW-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FuncW-1:0] FUNC_READ   = 2'd1;
   localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;

   localparam logic [CsrIdxW-1:0] CSR_CORE_SIZE   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_READ_LIMIT  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_WRITE_LIMIT = 2'd2;

   localparam logic [ModeW-1:0] MODE_IMM       = 3'd0;
   localparam logic [ModeW-1:0] MODE_DIR       = 3'd1;
   localparam logic [ModeW-1:0] MODE_A_PREDEC  = 3'd4;
   localparam logic [ModeW-1:0] MODE_B_PREDEC  = 3'd5;
   localparam logic [ModeW-1:0] MODE_A_POSTINC = 3'd6;
   localparam logic [ModeW-1:0] MODE_B_POSTINC = 3'd7;

   typedef struct packed {
      logic [FuncW-1:0] func;
      logic [NumW-1:0]  address;
      logic [WordW-1:0] word;
   } req_type;

   typedef struct packed {
      logic [WordW-1:0] instr_word;
      logic [NumW-1:0]  read_ptr_a;
      logic [NumW-1:0]  write_ptr_a;
      logic [NumW-1:0]  read_ptr_b;
      logic [NumW-1:0]  write_ptr_b;
      logic [WordW-1:0] a_operand_word;
      logic [WordW-1:0] b_operand_word;
   } rsp_type;

   typedef enum logic [2:0] {
      SRC_ADDR, SRC_NUM_R, SRC_NUM_W, SRC_DEC, SRC_INC, SRC_RP_IND, SRC_WP_IND
   } div_src_type;

   typedef enum logic [1:0] {
      ADDR_PC, ADDR_PC_RP, ADDR_PC_WP, ADDR_PIP
   } addr_sel_type;

   typedef enum logic [1:0] {
      WR_NONE, WR_WORD, WR_NUM
   } wr_type;

   typedef enum logic [2:0] {
      CAP_NONE, CAP_PC, CAP_IR, CAP_RP, CAP_WP, CAP_OPW
   } cap_type;

   typedef struct packed {
      logic         accept;
      logic         opb;
      logic         div_start;
      div_src_type  div_src;
      logic         rd;
      addr_sel_type addr_sel;
      wr_type       wr;
      cap_type      cap;
      logic         clr_res;
      logic         clr_ptrs;
      logic         set_pip;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [FuncW-1:0] func;
      logic [ModeW-1:0] mode;
      logic             div_done;
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PC_START, ST_PC_WAIT, ST_LOAD_WR, ST_IR_RD, ST_IR_CAP,
      ST_OP_START, ST_NR_START, ST_NR_WAIT, ST_NW_START, ST_NW_WAIT, ST_PIP_SET,
      ST_PD_RD, ST_PD_USE, ST_PD_WAIT, ST_IR_IND_RD, ST_IR_IND_USE, ST_IR_IND_WAIT,
      ST_IW_IND_RD, ST_IW_IND_USE, ST_IW_IND_WAIT, ST_FETCH_RD, ST_FETCH_CAP,
      ST_PO_RD, ST_PO_USE, ST_PO_WAIT, ST_OP_NEXT, ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/core/rcoe_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring remainder, one dividend bit per cycle
module rcoe_divider import rcoe_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [SumW-1:0] dividend,
   input  wire logic [RegW-1:0] divisor,
   output logic                 done,
   output logic [RegW-1:0]      rem
);

   localparam int CntW = $clog2(SumW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [SumW-1:0] sh_ff, sh_in;
   logic [RegW-1:0] rem_ff, rem_in;
   logic [RegW-1:0] div_ff, div_in;
   logic [SumW-1:0] trial;
   logic [SumW-1:0] diff;

   always_comb begin
      trial   = {rem_ff, sh_ff[SumW-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(SumW);
         sh_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[SumW-2:0], 1'b0};
         rem_in = (trial >= {1'b0, div_ff}) ? diff[RegW-1:0] : trial[RegW-1:0];
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ===== rtl/core/rcoe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rcoe_datapath import rcoe_pkg::*; #(
   parameter int CORE_DEPTH = CoreDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [RegW-1:0]    csr_wdata,
   input  wire req_type            req_data,
   input  wire cmd_type            cmd,
   output status_type              status,
   output rsp_type                 rsp_data
);

   localparam int AddrW    = (CORE_DEPTH > 2) ? $clog2(CORE_DEPTH) : 1;
   localparam int RegMax   = (1 << RegW) - 1;
   localparam int DepthCap = (CORE_DEPTH < RegMax) ? CORE_DEPTH : RegMax;

   logic [WordW-1:0] mem [CORE_DEPTH];

   logic [RegW-1:0]  core_size_ff, read_limit_ff, write_limit_ff;
   logic [FuncW-1:0] func_ff;
   logic [NumW-1:0]  addr_ff;
   logic [WordW-1:0] word_ff;
   logic [RegW-1:0]  pc_ff, rp_ff, wp_ff, pip_ff, ea_ff;
   logic [WordW-1:0] ir_ff, rdata_ff, wa_ff, wb_ff;
   logic [NumW-1:0]  rpa_ff, wpa_ff, rpb_ff, wpb_ff;
   rsp_type          rsp_ff;

   logic [RegW-1:0]  m_eff, rl_eff, wl_eff;
   logic [NumW-1:0]  num_ir, num_rd;
   logic [ModeW-1:0] mode;
   logic             sel;
   logic [SumW-1:0]  dividend;
   logic [RegW-1:0]  divisor;
   logic [RegW-1:0]  rd_addr;
   logic [WordW-1:0] patched;
   logic             div_done;
   logic [RegW-1:0]  div_rem;

   function automatic logic [RegW-1:0] clamp_limit(input logic [RegW-1:0] lim,
                                                   input logic [RegW-1:0] m);
      logic [RegW-1:0] r;
      r = lim;
      if (r == '0) r = RegW'(1);
      if (r > m) r = m;
      return r;
   endfunction

   // a, b below m
   function automatic logic [RegW-1:0] add_mod(input logic [RegW-1:0] a,
                                               input logic [RegW-1:0] b,
                                               input logic [RegW-1:0] m);
      logic [SumW-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[RegW-1:0];
   endfunction

   // upper half of the residue maps to the negative side of core
   function automatic logic [RegW-1:0] fold_fix(input logic [RegW-1:0] r,
                                                input logic [RegW-1:0] lim,
                                                input logic [RegW-1:0] m);
      logic [SumW-1:0] s;
      s = {1'b0, r} + {1'b0, m} - {1'b0, lim};
      return (r > (lim >> 1)) ? s[RegW-1:0] : r;
   endfunction

   always_comb begin
      m_eff = core_size_ff;
      if (core_size_ff < RegW'(2)) m_eff = RegW'(2);
      else if (core_size_ff > RegW'(DepthCap)) m_eff = RegW'(DepthCap);
      rl_eff = clamp_limit(read_limit_ff, m_eff);
      wl_eff = clamp_limit(write_limit_ff, m_eff);
   end

   assign num_ir = cmd.opb ? ir_ff[BnumLsb +: NumW] : ir_ff[AnumLsb +: NumW];
   assign mode   = cmd.opb ? ir_ff[BmodeLsb +: ModeW] : ir_ff[AmodeLsb +: ModeW];
   assign sel    = mode[0];
   assign num_rd = sel ? rdata_ff[BnumLsb +: NumW] : rdata_ff[AnumLsb +: NumW];

   always_comb begin
      patched = rdata_ff;
      if (sel) patched[BnumLsb +: NumW] = div_rem[NumW-1:0];
      else     patched[AnumLsb +: NumW] = div_rem[NumW-1:0];
   end

   always_comb begin
      case (cmd.div_src)
         SRC_ADDR: begin
            dividend = SumW'(addr_ff);
            divisor  = m_eff;
         end
         SRC_NUM_R: begin
            dividend = SumW'(num_ir);
            divisor  = rl_eff;
         end
         SRC_NUM_W: begin
            dividend = SumW'(num_ir);
            divisor  = wl_eff;
         end
         SRC_DEC: begin
            dividend = SumW'(num_rd) + SumW'(m_eff) - SumW'(1);
            divisor  = m_eff;
         end
         SRC_INC: begin
            dividend = SumW'(num_rd) + SumW'(1);
            divisor  = m_eff;
         end
         SRC_RP_IND: begin
            dividend = SumW'(rp_ff) + SumW'(num_rd);
            divisor  = rl_eff;
         end
         SRC_WP_IND: begin
            dividend = SumW'(wp_ff) + SumW'(num_rd);
            divisor  = wl_eff;
         end
         default: begin
            dividend = SumW'(addr_ff);
            divisor  = m_eff;
         end
      endcase
   end

   always_comb begin
      case (cmd.addr_sel)
         ADDR_PC:    rd_addr = pc_ff;
         ADDR_PC_RP: rd_addr = add_mod(pc_ff, rp_ff, m_eff);
         ADDR_PC_WP: rd_addr = add_mod(pc_ff, wp_ff, m_eff);
         ADDR_PIP:   rd_addr = pip_ff;
         default:    rd_addr = pc_ff;
      endcase
   end

   rcoe_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .rem      (div_rem)
   );

   // core memory
   always_ff @(posedge clock) begin
      if (cmd.wr == WR_WORD) mem[AddrW'(pc_ff)] <= word_ff;
      else if (cmd.wr == WR_NUM) mem[AddrW'(ea_ff)] <= patched;
      if (cmd.rd) rdata_ff <= mem[AddrW'(rd_addr)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_size_ff   <= CoreSizeReset;
         read_limit_ff  <= ReadLimitReset;
         write_limit_ff <= WriteLimitReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CORE_SIZE:   core_size_ff   <= csr_wdata;
            CSR_READ_LIMIT:  read_limit_ff  <= csr_wdata;
            CSR_WRITE_LIMIT: write_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_data.func;
         addr_ff <= req_data.address;
         word_ff <= req_data.word;
      end
      if (cmd.rd) ea_ff <= rd_addr;
      if (cmd.clr_ptrs) begin
         rp_ff <= '0;
         wp_ff <= '0;
      end
      if (cmd.set_pip) pip_ff <= add_mod(pc_ff, wp_ff, m_eff);
      if (cmd.clr_res) begin
         rpa_ff <= '0;
         wpa_ff <= '0;
         rpb_ff <= '0;
         wpb_ff <= '0;
         wa_ff  <= '0;
         wb_ff  <= '0;
      end
      case (cmd.cap)
         CAP_PC: pc_ff <= div_rem;
         CAP_IR: ir_ff <= rdata_ff;
         CAP_RP: rp_ff <= fold_fix(div_rem, rl_eff, m_eff);
         CAP_WP: wp_ff <= fold_fix(div_rem, wl_eff, m_eff);
         CAP_OPW: begin
            if (cmd.opb) begin
               rpb_ff <= rp_ff[NumW-1:0];
               wpb_ff <= wp_ff[NumW-1:0];
               wb_ff  <= rdata_ff;
            end else begin
               rpa_ff <= rp_ff[NumW-1:0];
               wpa_ff <= wp_ff[NumW-1:0];
               wa_ff  <= rdata_ff;
            end
         end
         default: ;
      endcase
      if (cmd.rsp_load) begin
         rsp_ff.instr_word     <= ir_ff;
         rsp_ff.read_ptr_a     <= rpa_ff;
         rsp_ff.write_ptr_a    <= wpa_ff;
         rsp_ff.read_ptr_b     <= rpb_ff;
         rsp_ff.write_ptr_b    <= wpb_ff;
         rsp_ff.a_operand_word <= wa_ff;
         rsp_ff.b_operand_word <= wb_ff;
      end
   end

   assign status.func     = func_ff;
   assign status.mode     = mode;
   assign status.div_done = div_done;
   assign rsp_data        = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/rcoe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rcoe_ctrl import rcoe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      opb_ff, opb_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      predec, postinc, direct;

   assign predec  = (status.mode == MODE_A_PREDEC) || (status.mode == MODE_B_PREDEC);
   assign postinc = (status.mode == MODE_A_POSTINC) || (status.mode == MODE_B_POSTINC);
   assign direct  = (status.mode == MODE_IMM) || (status.mode == MODE_DIR);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         opb_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         opb_ff       <= opb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      opb_in       = opb_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.opb      = opb_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PC_START;
            end
         end
         ST_PC_START: begin
            if (status.func == FUNC_UNUSED) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = SRC_ADDR;
               state_in      = ST_PC_WAIT;
            end
         end
         ST_PC_WAIT: begin
            if (status.div_done) begin
               cmd.cap  = CAP_PC;
               state_in = (status.func == FUNC_LOAD) ? ST_LOAD_WR : ST_IR_RD;
            end
         end
         ST_LOAD_WR: begin
            cmd.wr   = WR_WORD;
            state_in = ST_IDLE;
         end
         ST_IR_RD: begin
            cmd.rd       = 1'b1;
            cmd.addr_sel = ADDR_PC;
            cmd.clr_res  = 1'b1;
            state_in     = ST_IR_CAP;
         end
         ST_IR_CAP: begin
            cmd.cap = CAP_IR;
            opb_in  = 1'b0;
            state_in = (status.func == FUNC_READ) ? ST_DONE : ST_OP_START;
         end
         ST_OP_START: begin
            cmd.clr_ptrs = 1'b1;
            state_in = (status.mode == MODE_IMM) ? ST_FETCH_RD : ST_NR_START;
         end
         ST_NR_START: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = SRC_NUM_R;
            state_in      = ST_NR_WAIT;
         end
         ST_NR_WAIT: begin
            if (status.div_done) begin
               cmd.cap  = CAP_RP;
               state_in = ST_NW_START;
            end
         end
         ST_NW_START: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = SRC_NUM_W;
            state_in      = ST_NW_WAIT;
         end
         ST_NW_WAIT: begin
            if (status.div_done) begin
               cmd.cap  = CAP_WP;
               state_in = direct ? ST_FETCH_RD : ST_PIP_SET;
            end
         end
         ST_PIP_SET: begin
            cmd.set_pip = 1'b1;
            state_in    = predec ? ST_PD_RD : ST_IR_IND_RD;
         end
         ST_PD_RD: begin
            cmd.rd       = 1'b1;
            cmd.addr_sel = ADDR_PIP;
            state_in     = ST_PD_USE;
         end
         ST_PD_USE: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = SRC_DEC;
            state_in      = ST_PD_WAIT;
         end
         ST_PD_WAIT: begin
            if (status.div_done) begin
               cmd.wr   = WR_NUM;
               state_in = ST_IR_IND_RD;
            end
         end
         ST_IR_IND_RD: begin
            cmd.rd       = 1'b1;
            cmd.addr_sel = ADDR_PC_RP;
            state_in     = ST_IR_IND_USE;
         end
         ST_IR_IND_USE: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = SRC_RP_IND;
            state_in      = ST_IR_IND_WAIT;
         end
         ST_IR_IND_WAIT: begin
            if (status.div_done) begin
               cmd.cap  = CAP_RP;
               state_in = ST_IW_IND_RD;
            end
         end
         ST_IW_IND_RD: begin
            cmd.rd       = 1'b1;
            cmd.addr_sel = ADDR_PC_WP;
            state_in     = ST_IW_IND_USE;
         end
         ST_IW_IND_USE: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = SRC_WP_IND;
            state_in      = ST_IW_IND_WAIT;
         end
         ST_IW_IND_WAIT: begin
            if (status.div_done) begin
               cmd.cap  = CAP_WP;
               state_in = ST_FETCH_RD;
            end
         end
         ST_FETCH_RD: begin
            cmd.rd       = 1'b1;
            cmd.addr_sel = ADDR_PC_RP;
            state_in     = ST_FETCH_CAP;
         end
         ST_FETCH_CAP: begin
            cmd.cap  = CAP_OPW;
            state_in = postinc ? ST_PO_RD : ST_OP_NEXT;
         end
         ST_PO_RD: begin
            cmd.rd       = 1'b1;
            cmd.addr_sel = ADDR_PIP;
            state_in     = ST_PO_USE;
         end
         ST_PO_USE: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = SRC_INC;
            state_in      = ST_PO_WAIT;
         end
         ST_PO_WAIT: begin
            if (status.div_done) begin
               cmd.wr   = WR_NUM;
               state_in = ST_OP_NEXT;
            end
         end
         ST_OP_NEXT: begin
            if (opb_ff) begin
               state_in = ST_DONE;
            end else begin
               opb_in   = 1'b1;
               state_in = ST_OP_START;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/redcode_operand_evaluator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Redcode operand evaluator. Holds a core of 40-bit instruction words and
// takes one item at a time: load a word (no result), read a word, or
// evaluate both operands of the instruction at a program counter (folded
// read/write pointers, predecrement, one level of indirection, operand
// fetch, postincrement, all modulo core_size). Every modulo by a
// configured size or limit goes through one shared restoring remainder
// unit, and core is a single-port memory, so cost is set by the number
// of remainders and core accesses per item. A new item is accepted once
// the previous one has finished; a finished result waits in its own
// output register while the next item runs. Configuration must be
// written through csr_we/csr_index/csr_wdata only while the block is
// idle; the block itself does not enforce this. Core contents are
// undefined until loaded.
module redcode_operand_evaluator_top import rcoe_pkg::*; #(
   parameter int CORE_DEPTH = CoreDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [RegW-1:0]    csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer: a state machine that starts each core access and remainder operation in turn
   rcoe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // core memory, pointer registers, remainder unit, result register
   rcoe_datapath #(
      .CORE_DEPTH (CORE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
